@@ design/safs_pkg.sv @@
package safs_pkg;

    // Default widths of the time and tick counters
    localparam int TIME_BITS_DEF = 48;
    localparam int TICK_BITS_DEF = 32;

    // One second in microseconds; the frame period never exceeds it
    localparam int PER_W = 20;
    localparam logic [PER_W-1:0] US_PER_SECOND = PER_W'(1000000);

    // Field and register widths
    localparam int FRAME_W  = 8;
    localparam int FPS_W    = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_USER_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_VALID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE   = 2'd3;

    // Play modes; any other code plays ping-pong
    localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;

    // Input operations
    localparam logic OP_TIME  = 1'b0;
    localparam logic OP_START = 1'b1;

endpackage

@@ design/safs_div.sv @@
module safs_div #(
    parameter int TIME_BITS = safs_pkg::TIME_BITS_DEF,
    parameter int CNT_W     = $clog2(TIME_BITS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [CNT_W-1:0]           iters,     // quotient bits to produce
    input  logic [TIME_BITS-1:0]       dividend,  // left-aligned
    input  logic [safs_pkg::PER_W-1:0] divisor,   // held stable while busy
    output logic                       done,
    output logic [TIME_BITS-1:0]       quotient,
    output logic [safs_pkg::PER_W-1:0] remainder
);
    import safs_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] dvd_reg;
    logic [PER_W-1:0]     rem_reg;

    logic [PER_W:0]       trial;
    logic [PER_W:0]       diff;
    logic                 ge;

    // One restoring step per cycle
    assign trial = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
                dvd_reg  <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[TIME_BITS-2:0], ge};
                rem_reg <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Aligned dividend leaves zeros above the quotient bits
    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

@@ design/sprite_animation_frame_scheduler.sv @@
// Sprite animation frame scheduler.
// Input stream: s_tuser is the operation (0 time update, 1 start), s_tdata
// the current time in microseconds. Each accepted beat yields exactly one
// result beat: m_tdata is the frame number, m_tuser flags render, show
// default image and finished. Registers are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user writes them only while no item is in
// flight, which the block itself does not enforce. One item is worked at
// a time by a single restoring divider (one quotient bit per cycle) shared
// by three divisions: frame period (PER_W = 20 steps), whole periods
// elapsed (TIME_BITS steps) and frame position (TICK_BITS steps, loop and
// ping-pong only, with more than one frame). A time update with nothing
// due skips the divider; a start runs only the frame period division; a
// due time update runs the period and elapsed-periods divisions, then the
// frame position one outside once mode when there is more than one frame.
// s_tready is high only between items. The result sits in an output
// register; a new item is accepted while it waits, and the sequencer holds
// its next result until m_tready takes the old one.
// Reset clears the tick count, the due time and the stop flag, and loads
// the register defaults (no face, one frame, one frame per second, once).
module sprite_animation_frame_scheduler #(
    parameter int TIME_BITS = safs_pkg::TIME_BITS_DEF,
    parameter int TICK_BITS = safs_pkg::TICK_BITS_DEF,
    parameter int DATA_W    = ((TIME_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [safs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [safs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [DATA_W-1:0]               s_tdata,   // now_us
    input  logic                            s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [safs_pkg::FRAME_W-1:0]    m_tdata,   // frame_number
    output logic [safs_pkg::OUT_USER_W-1:0] m_tuser    // render, show_default, finished
);
    import safs_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PERIOD, ST_LATE, ST_STEP, ST_DUE, ST_MOD, ST_OUT
    } state_t;

    typedef enum logic [1:0] {RES_QUIET, RES_START, RES_FRAME} res_t;

    state_t               state_reg;
    res_t                 kind_reg;

    logic                 face_valid_reg;
    logic [FRAME_W-1:0]   frame_count_reg;
    logic [FPS_W-1:0]     fps_reg;
    logic [MODE_W-1:0]    play_mode_reg;

    logic                 op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [PER_W-1:0]     period_reg;
    logic [TIME_BITS-1:0] late_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic [TIME_BITS-1:0] due_reg;
    logic                 stopped_reg;
    logic [FRAME_W-1:0]   frame_reg;

    logic                 div_start_reg;
    logic [CNT_W-1:0]     div_iters_reg;
    logic [TIME_BITS-1:0] div_dvd_reg;
    logic [PER_W-1:0]     div_dvs_reg;
    logic                 div_done;
    logic [TIME_BITS-1:0] div_quo;
    logic [PER_W-1:0]     div_rem;

    logic                 m_tvalid_reg;
    logic [FRAME_W-1:0]   m_frame_reg;
    logic                 m_render_reg;
    logic                 m_default_reg;
    logic                 m_finished_reg;

    logic [TIME_BITS-1:0] add_a;
    logic [TIME_BITS-1:0] add_b;
    logic [TIME_BITS:0]   add_sum;
    logic [TIME_BITS-1:0] add_sat;

    logic [FRAME_W-1:0]   count_c;
    logic [FRAME_W:0]     span;
    logic [FRAME_W:0]     pos;
    logic                 s_fire;
    logic                 quiet;
    logic                 stop_now;

    safs_div #(
        .TIME_BITS (TIME_BITS),
        .CNT_W     (CNT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .iters     (div_iters_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign quiet = (s_tuser == OP_TIME) &&
                   (!face_valid_reg || stopped_reg || (s_tdata[TIME_BITS-1:0] < due_reg));

    assign count_c  = (frame_count_reg == '0) ? FRAME_W'(1) : frame_count_reg;
    assign span     = {count_c, 1'b0} - (FRAME_W + 1)'(2);
    assign pos      = div_rem[FRAME_W:0];
    assign stop_now = (play_mode_reg == MODE_ONCE) &&
                      (tick_reg >= TICK_BITS'(count_c - FRAME_W'(1)));

    // Shared saturating adder
    always_comb begin
        case (state_reg)
            ST_PERIOD: begin
                add_a = now_reg;
                add_b = TIME_BITS'(div_quo[PER_W-1:0]);
            end
            ST_STEP: begin
                add_a = late_reg;
                add_b = TIME_BITS'(period_reg);
            end
            default: begin
                add_a = due_reg;
                add_b = late_reg;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_valid_reg  <= 1'b0;
            frame_count_reg <= FRAME_W'(1);
            fps_reg         <= '0;
            play_mode_reg   <= MODE_ONCE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FACE_VALID:  face_valid_reg  <= cfg_wdata[0];
                CFG_FRAME_COUNT: frame_count_reg <= cfg_wdata[FRAME_W-1:0];
                CFG_FPS:         fps_reg         <= cfg_wdata[FPS_W-1:0];
                CFG_PLAY_MODE:   play_mode_reg   <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= RES_QUIET;
            tick_reg      <= '0;
            due_reg       <= '0;
            stopped_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // start is a one-cycle pulse
            if (div_start_reg) begin
                div_start_reg <= 1'b0;
            end
            // ST_OUT reloads the output register itself
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        op_reg  <= s_tuser;
                        now_reg <= s_tdata[TIME_BITS-1:0];
                        if (quiet) begin
                            kind_reg  <= RES_QUIET;
                            state_reg <= ST_OUT;
                        end else begin
                            // fps of zero: 1000000 / 1 gives one frame a second
                            div_start_reg <= 1'b1;
                            div_iters_reg <= CNT_W'(PER_W);
                            div_dvd_reg   <= TIME_BITS'(US_PER_SECOND) << (TIME_BITS - PER_W);
                            div_dvs_reg   <= (fps_reg == '0) ? PER_W'(1) : PER_W'(fps_reg);
                            state_reg     <= ST_PERIOD;
                        end
                    end
                end
                ST_PERIOD: begin
                    if (div_done) begin
                        period_reg <= div_quo[PER_W-1:0];
                        if (op_reg == OP_START) begin
                            tick_reg  <= '0;
                            due_reg   <= add_sat;
                            kind_reg  <= RES_START;
                            state_reg <= ST_OUT;
                        end else begin
                            late_reg      <= now_reg - due_reg;
                            div_start_reg <= 1'b1;
                            div_iters_reg <= CNT_W'(TIME_BITS);
                            div_dvd_reg   <= now_reg - due_reg;
                            div_dvs_reg   <= div_quo[PER_W-1:0];
                            state_reg     <= ST_LATE;
                        end
                    end
                end
                ST_LATE: begin
                    if (div_done) begin
                        tick_reg  <= tick_reg + div_quo[TICK_BITS-1:0] + TICK_BITS'(1);
                        // whole periods of lateness
                        late_reg  <= late_reg - TIME_BITS'(div_rem);
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    late_reg  <= add_sat;
                    state_reg <= ST_DUE;
                end
                ST_DUE: begin
                    due_reg  <= add_sat;
                    kind_reg <= RES_FRAME;
                    if (count_c == FRAME_W'(1)) begin
                        frame_reg <= '0;
                        state_reg <= ST_OUT;
                    end else if (play_mode_reg == MODE_ONCE) begin
                        frame_reg <= (tick_reg >= TICK_BITS'(count_c)) ?
                                     count_c - FRAME_W'(1) : tick_reg[FRAME_W-1:0];
                        state_reg <= ST_OUT;
                    end else begin
                        div_start_reg <= 1'b1;
                        div_iters_reg <= CNT_W'(TICK_BITS);
                        div_dvd_reg   <= TIME_BITS'(tick_reg) << (TIME_BITS - TICK_BITS);
                        div_dvs_reg   <= (play_mode_reg == MODE_LOOP) ?
                                         PER_W'(count_c) : PER_W'(span);
                        state_reg     <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (div_done) begin
                        // ping-pong folds the back half of the span
                        if (play_mode_reg == MODE_LOOP || pos < {1'b0, count_c}) begin
                            frame_reg <= pos[FRAME_W-1:0];
                        end else begin
                            frame_reg <= FRAME_W'(span - pos);
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        case (kind_reg)
                            RES_START: begin
                                m_render_reg   <= 1'b1;
                                m_frame_reg    <= '0;
                                m_default_reg  <= !face_valid_reg;
                                m_finished_reg <= 1'b0;
                                stopped_reg    <= 1'b0;
                            end
                            RES_FRAME: begin
                                m_render_reg   <= 1'b1;
                                m_frame_reg    <= frame_reg;
                                m_default_reg  <= 1'b0;
                                m_finished_reg <= stop_now;
                                stopped_reg    <= stop_now;
                            end
                            default: begin
                                m_render_reg   <= 1'b0;
                                m_frame_reg    <= '0;
                                m_default_reg  <= 1'b0;
                                m_finished_reg <= stopped_reg;
                            end
                        endcase
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_frame_reg;
    assign m_tuser  = {m_finished_reg, m_default_reg, m_render_reg};

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import safs_pkg::*;

    localparam int TIME_W = TIME_BITS_DEF;
    localparam int DATA_W = ((TIME_W + 7) / 8) * 8;
    localparam longint unsigned TIME_ALL = (64'd1 << TIME_W) - 1;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 400;

    // ping-pong has no name in the package; code 3 plays the same way
    localparam logic [MODE_W-1:0] MODE_PINGPONG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PINGPONG3 = 2'd3;

    typedef struct {
        logic               op;
        logic [TIME_W-1:0]  now;
    } stamp_t;

    typedef struct packed {
        logic               finished;
        logic               show_default;
        logic               render;
        logic [FRAME_W-1:0] frame;
    } frame_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  s_tuser = OP_TIME;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [FRAME_W-1:0]    m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    sprite_animation_frame_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // scheduler copy: registers and state after reset
    logic              face_on = 1'b0;
    logic [FRAME_W-1:0] n_frames = 8'd1;
    logic [FPS_W-1:0]  fps_reg = '0;
    logic [MODE_W-1:0] mode_reg = MODE_ONCE;
    logic [31:0]       tick = '0;
    longint unsigned   due_at = 0;
    logic              halted = 1'b0;

    stamp_t stamp_q[$];
    frame_t frame_q[$];
    int     mismatches = 0;
    int     frames_seen = 0;

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        return (b > TIME_ALL - a) ? TIME_ALL : a + b;
    endfunction

    function automatic frame_t next_frame(logic op, logic [TIME_W-1:0] now_in);
        longint unsigned now, per, cnt, late, span, pos, tk;
        frame_t r;
        now = now_in;
        per = (fps_reg == 0) ? 64'd1000000 : 64'd1000000 / fps_reg;
        cnt = (n_frames == 0) ? 64'd1 : 64'(n_frames);
        r = '0;
        if (op == OP_START) begin
            tick = '0;
            due_at = add_sat(now, per);
            halted = 1'b0;
            r.render = 1'b1;
            r.show_default = !face_on;
            return r;
        end
        if (!face_on || halted || now < due_at) begin
            r.finished = halted;
            return r;
        end
        late = now - due_at;
        tick = 32'(64'(tick) + late / per + 1);
        due_at = add_sat(due_at, add_sat(late - late % per, per));
        tk = 64'(tick);
        r.render = 1'b1;
        if (cnt <= 1)
            r.frame = '0;
        else if (mode_reg == MODE_ONCE)
            r.frame = FRAME_W'(tk >= cnt ? cnt - 1 : tk);
        else if (mode_reg == MODE_LOOP)
            r.frame = FRAME_W'(tk % cnt);
        else begin
            span = cnt * 2 - 2;
            pos = tk % span;
            r.frame = FRAME_W'(pos < cnt ? pos : span - pos);
        end
        if (mode_reg == MODE_ONCE && tk >= cnt - 1)
            halted = 1'b1;
        r.finished = halted;
        return r;
    endfunction

    // driver: bursts of beats with random gaps, valid held until taken
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        stamp_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                frame_q.push_back(next_frame(s_tuser, s_tdata[TIME_W-1:0]));
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (stamp_q.size() != 0) begin
                    item = stamp_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= item.op;
                    s_tdata <= DATA_W'(item.now);
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: result checks plus the receiver's stall pattern
    logic [15:0] rdy_pat = 16'hFFFF;
    int          rdy_bits = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge aclk) begin
        frame_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                frames_seen++;
                if (frame_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: frame %0d user %b", m_tdata, m_tuser);
                end else begin
                    e = frame_q.pop_front();
                    if (m_tdata !== e.frame || m_tuser[0] !== e.render ||
                        m_tuser[1] !== e.show_default || m_tuser[2] !== e.finished) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp frame %0d render %b default %b ",
                                      "finished %b, got frame %0d render %b default %b ",
                                      "finished %b"},
                                     e.frame, e.render, e.show_default, e.finished,
                                     m_tdata, m_tuser[0], m_tuser[1], m_tuser[2]);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && frames_seen >= 120 && stamp_q.size() > 8) begin
                // long back-pressure so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                if (rdy_bits == 0) begin
                    rdy_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                    rdy_bits = 16;
                end
                m_tready <= rdy_pat[0];
                rdy_pat = rdy_pat >> 1;
                rdy_bits--;
            end
        end
    end

    int quiet = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic push(input logic op, input longint unsigned now);
        stamp_t s;
        s.op = op;
        s.now = TIME_W'(now > TIME_ALL ? TIME_ALL : now);
        stamp_q.push_back(s);
    endtask

    // checked between edges so the driver's last beat is already visible
    task automatic drain();
        do
            @(negedge aclk);
        while (stamp_q.size() != 0 || s_tvalid || frame_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_regs(input logic face, input logic [7:0] cnt,
                            input logic [7:0] fps, input logic [MODE_W-1:0] mode);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FACE_VALID;
        cfg_wdata <= CFG_DATA_W'(face);
        @(posedge aclk);
        cfg_index <= CFG_FRAME_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_index <= CFG_FPS;
        cfg_wdata <= fps;
        @(posedge aclk);
        cfg_index <= CFG_PLAY_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        face_on = face;
        n_frames = cnt;
        fps_reg = fps;
        mode_reg = mode;
    endtask

    logic [MODE_W-1:0] modes[4] = '{MODE_ONCE, MODE_LOOP, MODE_PINGPONG, MODE_PINGPONG3};

    initial begin : stimulus
        longint unsigned t, per;
        int sent, n;
        logic [7:0] cnt, fps;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset registers: no face, time beats stay silent
        push(OP_TIME, 0);
        push(OP_START, 48'h1234_5678_9ABC);
        push(OP_TIME, TIME_ALL);
        drain();

        // play once: early, due, late past the end, stopped, saturated due time
        set_regs(1'b1, 8'd4, 8'd0, MODE_ONCE);
        push(OP_START, 0);
        push(OP_TIME, 999_999);
        push(OP_TIME, 1_000_000);
        push(OP_TIME, 3_500_000);
        push(OP_TIME, 4_000_000);
        push(OP_START, TIME_ALL - 5);
        push(OP_TIME, TIME_ALL);
        push(OP_TIME, TIME_ALL);
        drain();

        // zero frames, fastest rate, mode code 3, huge jump wraps the tick
        set_regs(1'b1, 8'd0, 8'd255, MODE_PINGPONG3);
        push(OP_START, 0);
        push(OP_TIME, 3921);
        push(OP_TIME, 48'h8000_0000_0000);
        push(OP_TIME, TIME_ALL);
        drain();

        set_regs(1'b1, 8'd255, 8'd1, MODE_LOOP);
        push(OP_START, 0);
        push(OP_TIME, 64'd300_000_000);
        push(OP_TIME, 64'd300_999_999);
        drain();

        // ping-pong turning at the top frame
        set_regs(1'b1, 8'd255, 8'd255, MODE_PINGPONG);
        push(OP_START, 100);
        push(OP_TIME, 100 + 3921 * 253);
        push(OP_TIME, 100 + 3921 * 254);
        push(OP_TIME, 100 + 3921 * 255);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: cnt = 8'd0;
                1: cnt = 8'd1;
                2: cnt = 8'd2;
                3: cnt = 8'd255;
                4: cnt = 8'($urandom_range(3, 12));
                default: cnt = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0: fps = 8'd0;
                1: fps = 8'd1;
                2: fps = 8'd255;
                3: fps = 8'($urandom_range(20, 120));
                default: fps = 8'($urandom_range(1, 255));
            endcase
            set_regs($urandom_range(0, 7) != 0, cnt, fps, modes[2'($urandom_range(0, 3))]);
            per = (fps == 0) ? 64'd1000000 : 64'd1000000 / fps;
            case ($urandom_range(0, 3))
                0: t = TIME_ALL - $urandom_range(0, 32'(3 * per));
                1: t = $urandom_range(0, 1000);
                default: t = {$urandom, $urandom} & TIME_ALL;
            endcase
            // mostly a start followed by advancing time, with some noise mixed in
            if ($urandom_range(0, 7) != 0)
                push(OP_START, t);
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 11))
                    0: begin
                        t = {$urandom, $urandom} & TIME_ALL;
                        push(OP_TIME, t);
                    end
                    1: begin
                        t = t + {$urandom_range(0, 255), $urandom};
                        push(OP_TIME, t);
                    end
                    2: push(OP_START, t);
                    3: push(OP_TIME, t);
                    default: begin
                        t = t + $urandom_range(0, 32'(2 * per));
                        push(OP_TIME, t);
                    end
                endcase
                if (t > TIME_ALL)
                    t = TIME_ALL;
            end
            sent += n;
            drain();
        end

        while (stamp_q.size() != 0 || s_tvalid || frame_q.size() != 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (mismatches == 0 && frame_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
